@@ hdl/knob_speed_stepper_pulse_control_macros.svh @@
// ----------------------------------------------------------------------------
// Knob speed stepper pulse control: assertion macros
// Concurrent assertion shorthands shared by the controller and the datapath.
// ----------------------------------------------------------------------------
`ifndef KNOB_SPEED_STEPPER_PULSE_CONTROL_MACROS_SVH
`define KNOB_SPEED_STEPPER_PULSE_CONTROL_MACROS_SVH
`ifndef NO_ASSERTIONS
// The consequent must hold in the same cycle as the antecedent.
`define KSSP_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define KSSP_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);
`else
`define KSSP_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons, msg)
`define KSSP_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg)
`endif
`endif

@@ hdl/kssp_pkg.sv @@
// ----------------------------------------------------------------------------
// Knob speed stepper pulse control: package
// Widths, register indexes, mode codes and the types shared between modules.
// ----------------------------------------------------------------------------
package kssp_pkg;

  localparam int unsigned POS_W      = 7;
  localparam int unsigned STEP_W     = 7;
  localparam int unsigned SPS_W      = 16;
  localparam int unsigned CUR_W      = 11;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned POSITION_MAX_DEF = 100;
  localparam int unsigned POS_MID          = 50;
  localparam int unsigned ONE_MILLION      = 1000000;

  // The divider covers both position * max_sps (below 2^23) and one million.
  localparam int unsigned DIV_W             = 24;
  localparam int unsigned DIV_BITS_PER_STEP = 2;
  localparam int unsigned DIV_STEPS         = DIV_W / DIV_BITS_PER_STEP;
  localparam int unsigned DIV_CNT_W         = $clog2(DIV_STEPS);

  localparam logic [STEP_W-1:0] KNOB_STEP_RST   = 7'd4;
  localparam logic [SPS_W-1:0]  NORMAL_SPS_RST  = 16'd2000;
  localparam logic [SPS_W-1:0]  TURBO_SPS_RST   = 16'd4000;
  localparam logic [CUR_W-1:0]  NORMAL_CUR_RST  = 11'd1000;
  localparam logic [CUR_W-1:0]  TURBO_CUR_RST   = 11'd1400;

  localparam logic [CFG_IDX_W-1:0] CFG_KNOB_STEP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_SPS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TURBO_SPS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_CUR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TURBO_CUR  = 3'd4;

  localparam logic [MODE_W-1:0] MODE_IDLE    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_GRIND   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REVERSE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_TURBO   = 2'd3;

  typedef struct packed {
    logic              grind_pressed;
    logic              turbo_pressed;
    logic              enc_a;
    logic              enc_b;
    logic [TIME_W-1:0] now_us;
  } in_item_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              mode_changed;
    logic              motor_enable;
    logic              forward;
    logic [CUR_W-1:0]  current_ma;
    logic              step_pulse;
    logic [POS_W-1:0]  knob_position;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic div_start;
    logic div_sel;     // 0: speed division, 1: interval division
    logic cmp;
    logic out_load;
  } kssp_cmd_t;

  typedef struct packed {
    logic in_idle;
    logic div_last;
    logic speed_zero;
    logic out_free;
  } kssp_sts_t;

endpackage

@@ hdl/kssp_if.sv @@
// ----------------------------------------------------------------------------
// Knob speed stepper pulse control: channel interfaces
// Valid/ready channels for the sample input and the result output.
// ----------------------------------------------------------------------------
interface kssp_in_if;
  import kssp_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface kssp_out_if;
  import kssp_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hdl/knob_speed_stepper_pulse_control.sv @@
// ----------------------------------------------------------------------------
// Knob speed stepper pulse control: top level
// Turns button, encoder and time samples into motor mode, current and step
// pulses.
// ----------------------------------------------------------------------------
// Each input beat is one time-stamped sample and gives exactly one result
// beat. A sample in idle mode (no button pressed) goes from accept straight
// to the output hand-over; any other sample runs the divider twice, or once
// when the speed works out to zero. The work is done by one shared divider
// producing two quotient bits a cycle, run first for the speed (position
// times the mode's maximum over POSITION_MAX) and then for the step interval
// (one million over the speed). A new sample is taken as soon as the previous
// one is finished, even while its result still waits at the output.
// Configuration writes take effect on the next sample.
module knob_speed_stepper_pulse_control #(
  parameter int unsigned POSITION_MAX = kssp_pkg::POSITION_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  kssp_in_if.sink                         in_ch,
  kssp_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [kssp_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [kssp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import kssp_pkg::*;

  kssp_cmd_t cmd;
  kssp_sts_t sts;

  kssp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  kssp_dp #(
    .POSITION_MAX (POSITION_MAX)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_ch.data),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_data  (out_ch.data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

endmodule

@@ hdl/kssp_ctrl.sv @@
// ----------------------------------------------------------------------------
// Knob speed stepper pulse control: controller
// Sequences sample capture, the two divisions, the step decision and the
// hand-over of the result to the output register.
// ----------------------------------------------------------------------------
`include "knob_speed_stepper_pulse_control_macros.svh"

module kssp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  kssp_pkg::kssp_sts_t sts,
  output kssp_pkg::kssp_cmd_t cmd
);
  import kssp_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_DIV1  = 3'd2;
  localparam logic [2:0] S_SPD   = 3'd3;
  localparam logic [2:0] S_DIV2  = 3'd4;
  localparam logic [2:0] S_CMP   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.accept    = accept;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = sts.in_idle ? S_OUT : S_START;
        end
      end
      S_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = 1'b0;
        state_nxt     = S_DIV1;
      end
      S_DIV1: begin
        if (sts.div_last) begin
          state_nxt = S_SPD;
        end
      end
      S_SPD: begin
        // A speed of zero never fires a pulse, so the interval is not needed.
        if (sts.speed_zero) begin
          state_nxt = S_OUT;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = 1'b1;
          state_nxt     = S_DIV2;
        end
      end
      S_DIV2: begin
        if (sts.div_last) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `KSSP_ASSERT_NXT(a_accept_leaves_idle, clk, rst_n, accept, state_r != S_IDLE, "accepted beat left the controller idle")
  `KSSP_ASSERT_NOW(a_load_when_free, clk, rst_n, cmd.out_load, sts.out_free, "result loaded over an untaken beat")
  `KSSP_ASSERT_NOW(a_wait_div, clk, rst_n, (state_r == S_DIV1 || state_r == S_DIV2) && !sts.div_last, state_nxt == state_r, "division stage left early")

endmodule

@@ hdl/kssp_dp.sv @@
// ----------------------------------------------------------------------------
// Knob speed stepper pulse control: datapath
// Configuration registers, knob and mode state, the shared iterative divider,
// the step-time comparison and the output register.
// ----------------------------------------------------------------------------
`include "knob_speed_stepper_pulse_control_macros.svh"

module kssp_dp #(
  parameter int unsigned POSITION_MAX = kssp_pkg::POSITION_MAX_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  kssp_pkg::kssp_cmd_t               cmd,
  output kssp_pkg::kssp_sts_t               sts,
  input  kssp_pkg::in_item_t                in_data,
  input  logic                              out_ready,
  output logic                              out_valid,
  output kssp_pkg::out_item_t               out_data,
  input  logic                              cfg_we,
  input  logic [kssp_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [kssp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import kssp_pkg::*;

  localparam logic [POS_W-1:0] POS_MAX_V = POS_W'(POSITION_MAX);
  localparam logic [POS_W-1:0] POS_RESET =
    POS_W'((POSITION_MAX < POS_MID) ? POSITION_MAX : POS_MID);

  // Configuration registers
  logic [STEP_W-1:0] knob_step_r;
  logic [SPS_W-1:0]  normal_sps_r;
  logic [SPS_W-1:0]  turbo_sps_r;
  logic [CUR_W-1:0]  normal_cur_r;
  logic [CUR_W-1:0]  turbo_cur_r;

  // Knob, mode and step state
  logic [POS_W-1:0]  pos_r;
  logic [POS_W-1:0]  pos_nxt;
  logic              prev_a_r;
  logic [MODE_W-1:0] cur_mode_r;
  logic [TIME_W-1:0] last_r;

  // Per-sample working registers
  logic [TIME_W-1:0] now_r;
  logic [SPS_W-1:0]  base_r;
  out_item_t         res_r;
  out_item_t         out_data_r;
  logic              out_valid_r;

  logic signed [POS_W+1:0] pos_sum;
  logic [MODE_W-1:0]       mode_new;
  logic [CUR_W-1:0]        cur_new;

  // Divider
  logic [SPS_W:0]           rem_r;
  logic [SPS_W:0]           rem_w;
  logic [DIV_W-1:0]         quo_r;
  logic [DIV_W-1:0]         quo_w;
  logic [SPS_W-1:0]         dvs_r;
  logic [DIV_CNT_W-1:0]     div_cnt_r;
  logic                     div_busy_r;
  logic                     div_last;
  logic [SPS_W:0]           div_sh;
  logic [POS_W+SPS_W-1:0]   prod;
  logic [DIV_W-1:0]         dvd_mux;
  logic [SPS_W-1:0]         dvs_mux;

  logic [TIME_W-1:0] since_last;
  logic              step_due;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      knob_step_r  <= KNOB_STEP_RST;
      normal_sps_r <= NORMAL_SPS_RST;
      turbo_sps_r  <= TURBO_SPS_RST;
      normal_cur_r <= NORMAL_CUR_RST;
      turbo_cur_r  <= TURBO_CUR_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_KNOB_STEP:  knob_step_r  <= cfg_wdata[STEP_W-1:0];
        CFG_NORMAL_SPS: normal_sps_r <= cfg_wdata[SPS_W-1:0];
        CFG_TURBO_SPS:  turbo_sps_r  <= cfg_wdata[SPS_W-1:0];
        CFG_NORMAL_CUR: normal_cur_r <= cfg_wdata[CUR_W-1:0];
        CFG_TURBO_CUR:  turbo_cur_r  <= cfg_wdata[CUR_W-1:0];
        default: ;
      endcase
    end
  end

  // Encoder: A equal to B turns up, otherwise down, clamped to the range.
  always_comb begin
    if (in_data.enc_a == in_data.enc_b) begin
      pos_sum = $signed({2'b00, pos_r}) + $signed({2'b00, knob_step_r});
    end else begin
      pos_sum = $signed({2'b00, pos_r}) - $signed({2'b00, knob_step_r});
    end
    if (in_data.enc_a == prev_a_r) begin
      pos_nxt = pos_r;
    end else if (pos_sum < 0) begin
      pos_nxt = '0;
    end else if (pos_sum > $signed({2'b00, POS_MAX_V})) begin
      pos_nxt = POS_MAX_V;
    end else begin
      pos_nxt = pos_sum[POS_W-1:0];
    end
  end

  always_comb begin
    if (in_data.grind_pressed && in_data.turbo_pressed) begin
      mode_new = MODE_REVERSE;
    end else if (in_data.turbo_pressed) begin
      mode_new = MODE_TURBO;
    end else if (in_data.grind_pressed) begin
      mode_new = MODE_GRIND;
    end else begin
      mode_new = MODE_IDLE;
    end
    case (mode_new)
      MODE_IDLE:  cur_new = '0;
      MODE_TURBO: cur_new = turbo_cur_r;
      default:    cur_new = normal_cur_r;
    endcase
  end

  assign since_last = now_r - last_r;
  assign step_due   = (since_last >= TIME_W'(quo_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= POS_RESET;
      prev_a_r   <= 1'b1;
      cur_mode_r <= MODE_IDLE;
      last_r     <= '0;
    end else begin
      if (cmd.accept) begin
        pos_r      <= pos_nxt;
        prev_a_r   <= in_data.enc_a;
        cur_mode_r <= mode_new;
      end
      if (cmd.cmp && step_due) begin
        last_r <= now_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      now_r                <= in_data.now_us;
      base_r               <= (mode_new == MODE_TURBO) ? turbo_sps_r : normal_sps_r;
      res_r.mode           <= mode_new;
      res_r.mode_changed   <= (mode_new != cur_mode_r);
      res_r.motor_enable   <= (mode_new != MODE_IDLE);
      res_r.forward        <= (mode_new != MODE_REVERSE);
      res_r.current_ma     <= cur_new;
      res_r.step_pulse     <= 1'b0;
      res_r.knob_position  <= pos_nxt;
    end else if (cmd.cmp) begin
      res_r.step_pulse <= step_due;
    end
  end

  // Shared restoring divider, two quotient bits per cycle. The first run
  // gives the speed, the second the step interval in microseconds.
  assign prod    = pos_r * base_r;
  assign dvd_mux = cmd.div_sel ? DIV_W'(ONE_MILLION) : DIV_W'(prod);
  assign dvs_mux = cmd.div_sel ? quo_r[SPS_W-1:0] : SPS_W'(POSITION_MAX);

  always_comb begin
    rem_w  = rem_r;
    quo_w  = quo_r;
    div_sh = '0;
    for (int i = 0; i < DIV_BITS_PER_STEP; i++) begin
      div_sh = {rem_w[SPS_W-1:0], quo_w[DIV_W-1]};
      quo_w  = {quo_w[DIV_W-2:0], 1'b0};
      if (div_sh >= {1'b0, dvs_r}) begin
        rem_w    = div_sh - {1'b0, dvs_r};
        quo_w[0] = 1'b1;
      end else begin
        rem_w = div_sh;
      end
    end
  end

  assign div_last = div_busy_r && (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
      div_cnt_r  <= '0;
    end else if (cmd.div_start) begin
      div_busy_r <= 1'b1;
      div_cnt_r  <= '0;
    end else if (div_busy_r) begin
      div_cnt_r <= div_cnt_r + 1'b1;
      if (div_last) begin
        div_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_r <= '0;
      quo_r <= dvd_mux;
      dvs_r <= dvs_mux;
    end else if (div_busy_r) begin
      rem_r <= rem_w;
      quo_r <= quo_w;
    end
  end

  // Output register: a finished beat waits here while the next sample runs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sts.in_idle    = !(in_data.grind_pressed || in_data.turbo_pressed);
  assign sts.div_last   = div_last;
  assign sts.speed_zero = (quo_r == '0);
  assign sts.out_free   = !out_valid_r || out_ready;

  `KSSP_ASSERT_NOW(a_pos_in_range, clk, rst_n, 1'b1, pos_r <= POS_MAX_V, "knob position beyond its maximum")
  `KSSP_ASSERT_NOW(a_div_not_busy, clk, rst_n, cmd.div_start, !div_busy_r, "divider restarted while running")
  `KSSP_ASSERT_NOW(a_pulse_enabled, clk, rst_n, out_valid_r && out_data_r.step_pulse, out_data_r.motor_enable, "step pulse with the motor disabled")

endmodule

@@ verif/knob_speed_stepper_pulse_control_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Knob speed stepper pulse control: testbench
// A short table of directed samples is followed by phases of random,
// mostly well-formed samples, each phase under its own register setting.
// Every result beat is checked field by field against a predictor that
// runs in the testbench, or against the value written into a directed row,
// with random gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module knob_speed_stepper_pulse_control_tb;
  import kssp_pkg::*;

  localparam int unsigned POS_LIMIT   = POSITION_MAX_DEF;
  localparam int unsigned N_PHASES    = 8;
  localparam int unsigned PHASE_ITEMS = 200;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES = 600;
  localparam int unsigned HOLD_AFTER  = 300;
  localparam int unsigned MAX_REPORTS = 10;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    in_item_t              smp;
    logic                  typed;
    out_item_t             want;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  kssp_in_if  in_ch ();
  kssp_out_if out_ch ();

  knob_speed_stepper_pulse_control #(.POSITION_MAX(POS_LIMIT)) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  // Predictor copy of the registers and the block state.
  logic [STEP_W-1:0] knob_step_r;
  logic [SPS_W-1:0]  normal_sps_r;
  logic [SPS_W-1:0]  turbo_sps_r;
  logic [CUR_W-1:0]  normal_cur_r;
  logic [CUR_W-1:0]  turbo_cur_r;
  logic [POS_W-1:0]  knob_pos;
  logic              last_a;
  logic [MODE_W-1:0] mode_now;
  logic [TIME_W-1:0] pulse_time;

  out_item_t pending_results[$];
  int        mismatch_count = 0;
  int        results_seen   = 0;
  int        samples_sent   = 0;
  int        settings_used  = 0;
  int        pulses_seen    = 0;
  int        knob_at_zero   = 0;
  int        knob_at_full   = 0;
  logic [3:0] modes_seen    = '0;
  int        burst_left     = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin : watchdog
    #12_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic void reset_model();
    knob_step_r  = KNOB_STEP_RST;
    normal_sps_r = NORMAL_SPS_RST;
    turbo_sps_r  = TURBO_SPS_RST;
    normal_cur_r = NORMAL_CUR_RST;
    turbo_cur_r  = TURBO_CUR_RST;
    knob_pos     = (POS_MID < POS_LIMIT) ? POS_MID : POS_LIMIT;
    last_a       = 1'b1;
    mode_now     = MODE_IDLE;
    pulse_time   = '0;
  endfunction

  function automatic out_item_t predict_sample(input in_item_t s);
    out_item_t         r;
    int                pos_i;
    int                step_i;
    logic [MODE_W-1:0] m;
    logic [31:0]       top_sps;
    logic [31:0]       speed;
    logic [31:0]       interval;
    logic [31:0]       waited;
    // The knob moves first, so the speed below already sees the new position.
    if (s.enc_a != last_a) begin
      last_a = s.enc_a;
      pos_i  = knob_pos;
      step_i = knob_step_r;
      if (s.enc_a == s.enc_b) pos_i = pos_i + step_i;
      else pos_i = pos_i - step_i;
      if (pos_i < 0) pos_i = 0;
      else if (pos_i > int'(POS_LIMIT)) pos_i = POS_LIMIT;
      knob_pos = pos_i[POS_W-1:0];
    end
    if (s.grind_pressed && s.turbo_pressed) m = MODE_REVERSE;
    else if (s.turbo_pressed) m = MODE_TURBO;
    else if (s.grind_pressed) m = MODE_GRIND;
    else m = MODE_IDLE;
    r.mode         = m;
    r.mode_changed = (m != mode_now);
    mode_now       = m;
    r.motor_enable = (m != MODE_IDLE);
    r.forward      = (m != MODE_REVERSE);
    if (m == MODE_IDLE) r.current_ma = '0;
    else if (m == MODE_TURBO) r.current_ma = turbo_cur_r;
    else r.current_ma = normal_cur_r;
    r.step_pulse = 1'b0;
    if (m != MODE_IDLE) begin
      top_sps = (m == MODE_TURBO) ? turbo_sps_r : normal_sps_r;
      speed   = (knob_pos * top_sps) / POS_LIMIT;
      if (speed != 0) begin
        interval = ONE_MILLION / speed;
        waited   = s.now_us - pulse_time;
        if (waited >= interval) begin
          pulse_time   = s.now_us;
          r.step_pulse = 1'b1;
        end
      end
    end
    r.knob_position = knob_pos;
    return r;
  endfunction

  function automatic string fmt_result(input out_item_t r);
    return $sformatf("mode %0d chg %0d en %0d fwd %0d cur %0d pulse %0d pos %0d",
                     r.mode, r.mode_changed, r.motor_enable, r.forward,
                     r.current_ma, r.step_pulse, r.knob_position);
  endfunction

  task automatic note_failure(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("[%0t] %s", $time, what);
  endtask

  function automatic out_item_t result_of(input logic [MODE_W-1:0] m, input logic chg,
                                          input logic en, input logic fwd,
                                          input logic [CUR_W-1:0] cur, input logic pulse,
                                          input logic [POS_W-1:0] pos);
    out_item_t r;
    r.mode          = m;
    r.mode_changed  = chg;
    r.motor_enable  = en;
    r.forward       = fwd;
    r.current_ma    = cur;
    r.step_pulse    = pulse;
    r.knob_position = pos;
    return r;
  endfunction

  function automatic dir_row_t sample_row(input logic g, input logic t, input logic a,
                                          input logic b, input logic [TIME_W-1:0] now,
                                          input logic typed = 1'b0,
                                          input out_item_t want = '0);
    dir_row_t row;
    row.kind             = ROW_SAMPLE;
    row.reg_idx          = '0;
    row.reg_val          = '0;
    row.smp.grind_pressed = g;
    row.smp.turbo_pressed = t;
    row.smp.enc_a        = a;
    row.smp.enc_b        = b;
    row.smp.now_us       = now;
    row.typed            = typed;
    row.want             = want;
    return row;
  endfunction

  function automatic dir_row_t write_row(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] val);
    dir_row_t row;
    row.kind    = ROW_WRITE;
    row.reg_idx = idx;
    row.reg_val = val;
    row.smp     = '0;
    row.typed   = 1'b0;
    row.want    = '0;
    return row;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_reg(input int unsigned lo,
                                                     input int unsigned hi,
                                                     input int unsigned typ_hi,
                                                     input int unsigned width_max);
    case ($urandom_range(0, 7))
      0:       return lo;
      1:       return hi;
      2:       return width_max;
      3:       return 0;
      default: return $urandom_range(lo, typ_hi);
    endcase
  endfunction

  // Called just after a falling edge; returns just after a falling edge.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    case (idx)
      CFG_KNOB_STEP:  knob_step_r  = val[STEP_W-1:0];
      CFG_NORMAL_SPS: normal_sps_r = val[SPS_W-1:0];
      CFG_TURBO_SPS:  turbo_sps_r  = val[SPS_W-1:0];
      CFG_NORMAL_CUR: normal_cur_r = val[CUR_W-1:0];
      CFG_TURBO_CUR:  turbo_cur_r  = val[CUR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Offers one sample, with a random gap at the start of each burst.
  task automatic offer_sample(input in_item_t s, input logic typed, input out_item_t want);
    out_item_t guess;
    int        idle_cycles;
    if (burst_left == 0) begin
      burst_left  = $urandom_range(1, 40);
      idle_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (idle_cycles != 0) begin
        in_ch.valid <= 1'b0;
        repeat (idle_cycles) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.data  <= s;
    do @(posedge clk); while (!in_ch.ready);
    guess = predict_sample(s);
    pending_results.push_back(typed ? want : guess);
    samples_sent++;
    @(negedge clk);
  endtask

  always @(posedge clk) begin : result_check
    out_item_t want;
    out_item_t got;
    string     bad;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      results_seen++;
      if (got.step_pulse) pulses_seen++;
      modes_seen[got.mode] = 1'b1;
      if (got.knob_position == 0) knob_at_zero++;
      if (got.knob_position == POS_LIMIT) knob_at_full++;
      if (pending_results.size() == 0) begin
        note_failure({"unexpected result beat: ", fmt_result(got)});
      end else begin
        want = pending_results.pop_front();
        bad  = "";
        if (got.mode !== want.mode) bad = {bad, " mode"};
        if (got.mode_changed !== want.mode_changed) bad = {bad, " mode_changed"};
        if (got.motor_enable !== want.motor_enable) bad = {bad, " motor_enable"};
        if (got.forward !== want.forward) bad = {bad, " forward"};
        if (got.current_ma !== want.current_ma) bad = {bad, " current_ma"};
        if (got.step_pulse !== want.step_pulse) bad = {bad, " step_pulse"};
        if (got.knob_position !== want.knob_position) bad = {bad, " knob_position"};
        if (bad != "")
          note_failure($sformatf("result %0d differs in%s\n  expected %s\n  actual   %s",
                                 results_seen, bad, fmt_result(want), fmt_result(got)));
      end
    end
  end

  // Result side: random stall rates in spans, plus one long hold-off once the
  // run is well under way, so that the block backs up into its input.
  initial begin : result_sink
    int stall_pct;
    int span;
    bit held;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      case ($urandom_range(0, 4))
        0, 1:    stall_pct = 0;
        2:       stall_pct = 30;
        3:       stall_pct = 60;
        default: stall_pct = 90;
      endcase
      span = $urandom_range(16, 200);
      repeat (span) begin
        @(negedge clk);
        if (!held && results_seen >= HOLD_AFTER) begin
          held = 1'b1;
          out_ch.ready <= 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk);
        end else begin
          out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
      end
    end
  end

  initial begin : stimulus
    dir_row_t          dir_rows[$];
    in_item_t          s;
    logic [1:0]        quad[4];
    logic [1:0]        btn;
    logic [1:0]        enc_phase;
    logic [1:0]        enc_ab;
    logic [TIME_W-1:0] t_now;
    bit                spin_up;
    int                mode_left;
    int                pick;

    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    cfg_we      <= 1'b0;
    cfg_idx     <= '0;
    cfg_wdata   <= '0;
    reset_model();

    // Quadrature order: walking forward through this list turns the knob down.
    quad = '{2'b00, 2'b10, 2'b11, 2'b01};

    dir_rows.push_back(sample_row(0, 0, 1, 0, 32'd0, 1,
                                  result_of(MODE_IDLE, 0, 0, 1, 0, 0, 50)));
    dir_rows.push_back(sample_row(1, 0, 1, 1, 32'd0, 1,
                                  result_of(MODE_GRIND, 1, 1, 1, 1000, 0, 50)));
    dir_rows.push_back(sample_row(1, 0, 1, 1, 32'd1000, 1,
                                  result_of(MODE_GRIND, 0, 1, 1, 1000, 1, 50)));
    // One microsecond short of the interval, then exactly on it.
    dir_rows.push_back(sample_row(1, 0, 0, 0, 32'd1924));
    dir_rows.push_back(sample_row(1, 0, 0, 0, 32'd1925));
    dir_rows.push_back(sample_row(0, 1, 1, 0, 32'd2425));
    dir_rows.push_back(sample_row(1, 1, 1, 1, 32'd2426));
    dir_rows.push_back(sample_row(0, 0, 1, 1, 32'hFFFF_FFFF, 1,
                                  result_of(MODE_IDLE, 1, 0, 1, 0, 0, 50)));
    dir_rows.push_back(sample_row(1, 0, 1, 0, 32'd5));
    // A step above the range clamps the knob at both ends.
    dir_rows.push_back(write_row(CFG_KNOB_STEP, 16'd127));
    dir_rows.push_back(sample_row(1, 0, 0, 0, 32'd100));
    dir_rows.push_back(sample_row(1, 0, 1, 0, 32'd200, 1,
                                  result_of(MODE_GRIND, 0, 1, 1, 1000, 0, 0)));
    dir_rows.push_back(write_row(CFG_KNOB_STEP, 16'd0));
    dir_rows.push_back(sample_row(1, 0, 0, 0, 32'd300, 1,
                                  result_of(MODE_GRIND, 0, 1, 1, 1000, 0, 0)));
    dir_rows.push_back(write_row(CFG_KNOB_STEP, 16'd100));
    dir_rows.push_back(write_row(CFG_NORMAL_SPS, 16'd65535));
    dir_rows.push_back(write_row(CFG_TURBO_SPS, 16'd65535));
    dir_rows.push_back(write_row(CFG_NORMAL_CUR, 16'd2047));
    dir_rows.push_back(write_row(CFG_TURBO_CUR, 16'd0));
    dir_rows.push_back(sample_row(1, 0, 1, 1, 32'd400));
    dir_rows.push_back(sample_row(0, 1, 1, 1, 32'd415));
    dir_rows.push_back(sample_row(1, 1, 1, 1, 32'd429));
    dir_rows.push_back(write_row(CFG_NORMAL_SPS, 16'd0));
    dir_rows.push_back(write_row(CFG_TURBO_SPS, 16'd1));
    dir_rows.push_back(sample_row(1, 0, 1, 1, 32'd1000, 1,
                                  result_of(MODE_GRIND, 1, 1, 1, 2047, 0, 100)));
    dir_rows.push_back(sample_row(0, 1, 1, 1, 32'd1_000_500));
    dir_rows.push_back(sample_row(0, 1, 0, 1, 32'd2_000_000, 1,
                                  result_of(MODE_TURBO, 0, 1, 1, 0, 0, 0)));
    dir_rows.push_back(sample_row(0, 0, 1, 1, 32'd7, 1,
                                  result_of(MODE_IDLE, 1, 0, 1, 0, 0, 100)));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        if (i == 0 || dir_rows[i-1].kind != ROW_WRITE) drain_results();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
        if (i == dir_rows.size() - 1 || dir_rows[i+1].kind != ROW_WRITE) begin
          cfg_we <= 1'b0;
          settings_used++;
        end
      end else begin
        offer_sample(dir_rows[i].smp, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    enc_phase = 2'd0;
    spin_up   = 1'b1;
    mode_left = 0;
    btn       = 2'b00;
    for (int p = 0; p < N_PHASES; p++) begin
      drain_results();
      if (p == 0) begin
        write_reg(CFG_KNOB_STEP, 16'd1);
        write_reg(CFG_NORMAL_SPS, 16'd1);
        write_reg(CFG_TURBO_SPS, 16'd1);
        write_reg(CFG_NORMAL_CUR, 16'd0);
        write_reg(CFG_TURBO_CUR, 16'd0);
      end else if (p == 1) begin
        write_reg(CFG_KNOB_STEP, 16'(KNOB_STEP_RST));
        write_reg(CFG_NORMAL_SPS, NORMAL_SPS_RST);
        write_reg(CFG_TURBO_SPS, TURBO_SPS_RST);
        write_reg(CFG_NORMAL_CUR, 16'(NORMAL_CUR_RST));
        write_reg(CFG_TURBO_CUR, 16'(TURBO_CUR_RST));
      end else if (p == N_PHASES - 1) begin
        write_reg(CFG_KNOB_STEP, 16'd100);
        write_reg(CFG_NORMAL_SPS, 16'd65535);
        write_reg(CFG_TURBO_SPS, 16'd65535);
        write_reg(CFG_NORMAL_CUR, 16'd2000);
        write_reg(CFG_TURBO_CUR, 16'd2000);
      end else begin
        write_reg(CFG_KNOB_STEP, rand_reg(1, 100, 12, 127));
        write_reg(CFG_NORMAL_SPS, rand_reg(1, 65535, 5000, 65535));
        write_reg(CFG_TURBO_SPS, rand_reg(1, 65535, 5000, 65535));
        write_reg(CFG_NORMAL_CUR, rand_reg(0, 2000, 2000, 2047));
        write_reg(CFG_TURBO_CUR, rand_reg(0, 2000, 2000, 2047));
      end
      cfg_we <= 1'b0;
      settings_used++;

      // One phase starts just short of the time wrap.
      t_now = (p == 3) ? 32'hFFFF_F000 : $urandom;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (mode_left == 0) begin
          btn       = $urandom_range(0, 3);
          mode_left = $urandom_range(1, 60);
          if ($urandom_range(0, 2) == 0) spin_up = !spin_up;
        end
        mode_left--;
        pick = $urandom_range(0, 9);
        if (pick < 6) enc_phase = spin_up ? enc_phase - 2'd1 : enc_phase + 2'd1;
        else if (pick == 9) enc_phase = spin_up ? enc_phase + 2'd1 : enc_phase - 2'd1;
        // Mostly a clean quadrature walk; now and then a glitch on both lines.
        enc_ab = (pick == 8) ? 2'($urandom) : quad[enc_phase];
        case ($urandom_range(0, 15))
          0, 1, 2, 3, 4, 5, 6, 7, 8, 9: t_now = t_now + $urandom_range(0, 3000);
          10, 11, 12, 13:               t_now = t_now + $urandom_range(0, 32'h0020_0000);
          14:                           t_now = t_now + $urandom;
          default:                      t_now = t_now - $urandom_range(0, 1000);
        endcase
        s.grind_pressed = btn[1];
        s.turbo_pressed = btn[0];
        s.enc_a         = enc_ab[1];
        s.enc_b         = enc_ab[0];
        s.now_us        = t_now;
        offer_sample(s, 1'b0, '0);
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run summary: %0d samples under %0d register settings, %0d results, %0d pulses.",
             samples_sent, settings_used, results_seen, pulses_seen);
    $display("Modes seen %b (turbo down to idle), knob at zero %0d and full %0d, %0d bad beats.",
             modes_seen, knob_at_zero, knob_at_full, mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
